FILE: src/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

    localparam int RUN_DEPTH = 4;

    typedef enum logic [2:0] {
        CMD_TOGGLE    = 3'd0,
        CMD_DRAW      = 3'd1,
        CMD_ERASE     = 3'd2,
        CMD_ERASE_EOL = 3'd3,
        CMD_SCROLL    = 3'd4,
        CMD_CLEAR     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ESC_NORMAL = 2'd0,
        ESC_SEEN   = 2'd1,
        ESC_CSI    = 2'd2
    } esc_phase_t;

    typedef enum logic [1:0] {
        CFG_LEFT_COLUMN  = 2'd0,
        CFG_RIGHT_LIMIT  = 2'd1,
        CFG_TOP_ROW      = 2'd2,
        CFG_BOTTOM_LIMIT = 2'd3
    } cfg_index_t;

    localparam logic       ACT_PUT   = 1'b0;
    localparam logic       ACT_CLEAR = 1'b1;

    localparam logic [6:0] CH_BS      = 7'h08;
    localparam logic [6:0] CH_HT      = 7'h09;
    localparam logic [6:0] CH_NL      = 7'h0A;
    localparam logic [6:0] CH_VT      = 7'h0B;
    localparam logic [6:0] CH_CR      = 7'h0D;
    localparam logic [6:0] CH_ESC     = 7'h1B;
    localparam logic [6:0] CH_SPACE   = 7'h20;
    localparam logic [6:0] CH_DEL     = 7'h7F;
    localparam logic [6:0] CH_LBRACK  = 7'h5B;
    localparam logic [6:0] CH_UP      = 7'h41;
    localparam logic [6:0] CH_RIGHT   = 7'h43;
    localparam logic [6:0] CH_ERASE_K = 7'h4B;
    localparam logic [6:0] CH_HOME    = 7'h48;

    localparam logic [6:0] LEFT_COLUMN_RST  = 7'd8;
    localparam logic [7:0] RIGHT_LIMIT_RST  = 8'd96;
    localparam logic [5:0] TOP_ROW_RST      = 6'd2;
    localparam logic [6:0] BOTTOM_LIMIT_RST = 7'd48;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        cmd_t       command;
        logic [6:0] cell_column;
        logic [5:0] cell_row;
        logic [6:0] glyph;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [6:0] left_column;
        logic [7:0] right_limit;
        logic [5:0] top_row;
        logic [6:0] bottom_limit;
    } cfg_t;

    typedef struct packed {
        logic [6:0] column;
        logic [5:0] row;
        esc_phase_t phase;
    } cursor_t;

endpackage

`default_nettype wire

FILE: src/tcc_step.sv
`default_nettype none

module tcc_step (
    input  tcc_pkg::in_item_t                                item,
    input  tcc_pkg::cfg_t                                    cfg,
    input  tcc_pkg::cursor_t                                 cur,
    output tcc_pkg::out_item_t [tcc_pkg::RUN_DEPTH-1:0]      run,
    output logic [1:0]                                       last_idx,
    output tcc_pkg::cursor_t                                 cur_next
);
    import tcc_pkg::*;

    logic [6:0] c;
    logic [7:0] col_inc;
    logic [7:0] tab_stop;
    logic [6:0] row_inc;
    logic       row_scroll;
    logic [6:0] bottom_dec;
    logic [5:0] row_adv;
    logic [6:0] col;
    logic [5:0] row;
    logic [1:0] n;
    esc_phase_t phase;

    assign c          = item.char_code[6:0];
    assign col_inc    = {1'b0, cur.column} + 8'd1;
    assign tab_stop   = {({1'b0, cur.column[6:3]} + 5'd1), 3'b000};
    assign row_inc    = {1'b0, cur.row} + 7'd1;
    assign row_scroll = row_inc >= cfg.bottom_limit;
    assign bottom_dec = cfg.bottom_limit - 7'd1;
    assign row_adv    = row_scroll ? bottom_dec[5:0] : row_inc[5:0];

    // escape phase
    always_comb begin
        phase = cur.phase;
        if (item.action == ACT_PUT) begin
            unique case (cur.phase)
                ESC_SEEN: phase = (c == CH_LBRACK) ? ESC_CSI : ESC_NORMAL;
                ESC_CSI:  phase = ESC_NORMAL;
                default: begin
                    if (c == CH_ESC) phase = ESC_SEEN;
                end
            endcase
        end
    end

    // command run and cursor motion
    always_comb begin
        run = '0;
        col = cur.column;
        row = cur.row;
        n   = 2'd1;
        if (item.action == ACT_CLEAR) begin
            run[0].command = CMD_CLEAR;
            col = cfg.left_column;
            row = cfg.top_row;
        end else begin
            run[0].command     = CMD_TOGGLE;
            run[0].cell_column = cur.column;
            run[0].cell_row    = cur.row;
            unique case (cur.phase)
                ESC_SEEN: ;
                ESC_CSI: begin
                    unique case (c)
                        CH_UP: begin
                            if (cur.row > cfg.top_row) row = cur.row - 6'd1;
                        end
                        CH_RIGHT: begin
                            if (col_inc < cfg.right_limit) col = col_inc[6:0];
                        end
                        CH_ERASE_K: begin
                            if ({1'b0, cur.column} < cfg.right_limit) begin
                                run[1].command     = CMD_ERASE_EOL;
                                run[1].cell_column = cur.column;
                                run[1].cell_row    = cur.row;
                                n = 2'd2;
                            end
                        end
                        CH_HOME: begin
                            col = cfg.left_column;
                            row = cfg.top_row;
                        end
                        default: ;
                    endcase
                end
                default: begin
                    if (c >= CH_SPACE && c != CH_DEL) begin
                        run[1].command     = CMD_DRAW;
                        run[1].cell_column = cur.column;
                        run[1].cell_row    = cur.row;
                        run[1].glyph       = c;
                        n = 2'd2;
                        if (col_inc >= cfg.right_limit) begin
                            col = cfg.left_column;
                            row = row_adv;
                            if (row_scroll) begin
                                run[2].command     = CMD_SCROLL;
                                run[2].cell_column = cfg.left_column;
                                run[2].cell_row    = cfg.top_row;
                                n = 2'd3;
                            end
                        end else begin
                            col = col_inc[6:0];
                        end
                    end else begin
                        unique case (c)
                            CH_BS: begin
                                if (cur.column > cfg.left_column) col = cur.column - 7'd1;
                            end
                            CH_HT, CH_VT: begin
                                if (tab_stop < cfg.right_limit) col = tab_stop[6:0];
                            end
                            CH_NL: begin
                                row = row_adv;
                                if (row_scroll) begin
                                    run[1].command     = CMD_SCROLL;
                                    run[1].cell_column = cfg.left_column;
                                    run[1].cell_row    = cfg.top_row;
                                    n = 2'd2;
                                end
                            end
                            CH_CR: col = cfg.left_column;
                            CH_DEL: begin
                                if (cur.column > cfg.left_column) begin
                                    col = cur.column - 7'd1;
                                    run[1].command     = CMD_ERASE;
                                    run[1].cell_column = col;
                                    run[1].cell_row    = cur.row;
                                    n = 2'd2;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
        run[n].command     = CMD_TOGGLE;
        run[n].cell_column = col;
        run[n].cell_row    = row;
        run[n].glyph       = '0;
        run[n].last_of_run = 1'b1;
    end

    assign last_idx = n;
    assign cur_next = '{column: col, row: row, phase: phase};

endmodule

`default_nettype wire

FILE: src/text_console_cursor_control.sv
`default_nettype none

// Cursor and escape-sequence controller for a character console. Each input
// transfer (a character or a clear request) yields a run of two to four
// drawing commands on the m_ channel, one per cycle while m_ready is high,
// the last flagged by last_of_run. An accepted item waits in the input
// register until the run buffer is free, then its whole run is computed in
// a single pass and loaded into the run buffer; the next item loads as the
// last command of the previous run is taken, so sustained throughput is set
// by the single output port draining the run buffer. Configuration writes
// on cfg_* are always accepted and take effect at once; change them only
// while no run is pending.
module text_console_cursor_control (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  tcc_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output tcc_pkg::out_item_t   m_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  tcc_pkg::cfg_index_t  cfg_index,
    input  wire [7:0]            cfg_data
);
    import tcc_pkg::*;

    cfg_t                          cfg_reg;
    cursor_t                       cur_reg;
    cursor_t                       cur_next;
    in_item_t                      in_reg;
    logic                          in_valid_reg;
    out_item_t [RUN_DEPTH-1:0]     run_reg;
    out_item_t [RUN_DEPTH-1:0]     run_next;
    logic                          run_valid_reg;
    logic [1:0]                    idx_reg;
    logic [1:0]                    last_idx_reg;
    logic [1:0]                    last_idx_next;
    logic                          take;
    logic                          load;

    assign cfg_ready = 1'b1;
    assign take      = run_valid_reg && m_ready;
    assign load      = in_valid_reg && (!run_valid_reg || (take && idx_reg == last_idx_reg));
    assign s_ready   = !in_valid_reg || load;
    assign m_valid   = run_valid_reg;
    assign m_data    = run_reg[idx_reg];

    tcc_step u_step (
        .item     (in_reg),
        .cfg      (cfg_reg),
        .cur      (cur_reg),
        .run      (run_next),
        .last_idx (last_idx_next),
        .cur_next (cur_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left_column  <= LEFT_COLUMN_RST;
            cfg_reg.right_limit  <= RIGHT_LIMIT_RST;
            cfg_reg.top_row      <= TOP_ROW_RST;
            cfg_reg.bottom_limit <= BOTTOM_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LEFT_COLUMN:  cfg_reg.left_column  <= cfg_data[6:0];
                CFG_RIGHT_LIMIT:  cfg_reg.right_limit  <= cfg_data;
                CFG_TOP_ROW:      cfg_reg.top_row      <= cfg_data[5:0];
                CFG_BOTTOM_LIMIT: cfg_reg.bottom_limit <= cfg_data[6:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_reg <= s_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg.column <= LEFT_COLUMN_RST;
            cur_reg.row    <= TOP_ROW_RST;
            cur_reg.phase  <= ESC_NORMAL;
            run_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            last_idx_reg   <= '0;
        end else if (load) begin
            cur_reg       <= cur_next;
            run_valid_reg <= 1'b1;
            idx_reg       <= '0;
            last_idx_reg  <= last_idx_next;
        end else if (take) begin
            if (idx_reg == last_idx_reg) run_valid_reg <= 1'b0;
            else idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) run_reg <= run_next;
    end

    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        run_valid_reg |-> idx_reg <= last_idx_reg)
        else $error("run index past end of run");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_of_run == (idx_reg == last_idx_reg)))
        else $error("last_of_run disagrees with run length");

    a_run_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && idx_reg == 2'd0) |->
            (m_data.command == CMD_TOGGLE || m_data.command == CMD_CLEAR))
        else $error("run does not open with toggle or clear");

    a_run_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last_of_run) |-> m_data.command == CMD_TOGGLE)
        else $error("run does not close with cursor toggle");

    a_load_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && in_valid_reg) |-> load)
        else $error("input register overwritten before loading");

endmodule

`default_nettype wire

FILE: verif/tb.sv
module tb;
    import tcc_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_DIR        = 26;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 34;

    typedef struct packed {
        in_item_t   item;
        logic [2:0] n_typed;
    } dir_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    logic [7:0] cfg_data;

    // predictor state
    cfg_t       screen;
    logic [6:0] cur_col;
    logic [5:0] cur_row;
    esc_phase_t cur_phase;
    out_item_t  run_buf [RUN_DEPTH];
    int         run_len;

    out_item_t  awaited_cmds [$];
    out_item_t  want_cmd;
    int         errors = 0;
    int         cycles = 0;
    int         typed_pos = 0;
    int         sender_idle_pct = 0;
    int         recv_stall_pct = 0;

    // left, right, top, bottom, sender idle %, receiver stall %
    int screen_plan [N_PHASES][6] = '{
        '{8,   96,  2,  48, 0,  0},
        '{0,   1,   0,  1,  67, 0},
        '{127, 128, 63, 64, 0,  67},
        '{4,   24,  1,  6,  25, 25},
        '{120, 255, 0,  0,  0,  0},
        '{0,   0,   0,  0,  0,  67}
    };

    dir_row_t dir_rows [N_DIR] = '{
        '{'{ACT_PUT,   8'h41},             3'd3},
        '{'{ACT_CLEAR, 8'hFF},             3'd2},
        '{'{ACT_PUT,   8'hC1},             3'd0},
        '{'{ACT_PUT,   8'h7E},             3'd0},
        '{'{ACT_PUT,   {1'b0, CH_BS}},     3'd0},
        '{'{ACT_PUT,   {1'b0, CH_DEL}},    3'd0},
        '{'{ACT_PUT,   {1'b0, CH_HT}},     3'd0},
        '{'{ACT_PUT,   {1'b0, CH_VT}},     3'd0},
        '{'{ACT_PUT,   {1'b0, CH_NL}},     3'd0},
        '{'{ACT_PUT,   {1'b0, CH_CR}},     3'd0},
        '{'{ACT_PUT,   8'h00},             3'd0},
        '{'{ACT_PUT,   {1'b0, CH_ESC}},    3'd0},
        '{'{ACT_PUT,   {1'b0, CH_LBRACK}}, 3'd0},
        '{'{ACT_PUT,   {1'b0, CH_UP}},     3'd0},
        '{'{ACT_PUT,   {1'b0, CH_ESC}},    3'd0},
        '{'{ACT_PUT,   {1'b0, CH_LBRACK}}, 3'd0},
        '{'{ACT_PUT,   {1'b0, CH_ERASE_K}},3'd0},
        '{'{ACT_PUT,   {1'b0, CH_ESC}},    3'd0},
        '{'{ACT_PUT,   8'h78},             3'd0},
        '{'{ACT_PUT,   {1'b0, CH_ESC}},    3'd0},
        '{'{ACT_CLEAR, 8'h00},             3'd0},
        '{'{ACT_PUT,   {1'b0, CH_LBRACK}}, 3'd0},
        '{'{ACT_PUT,   {1'b0, CH_RIGHT}},  3'd0},
        '{'{ACT_PUT,   {1'b0, CH_ESC}},    3'd0},
        '{'{ACT_PUT,   {1'b0, CH_LBRACK}}, 3'd0},
        '{'{ACT_PUT,   {1'b0, CH_HOME}},   3'd0}
    };

    out_item_t dir_typed [5] = '{
        '{CMD_TOGGLE, 7'd8, 6'd2, 7'd0,  1'b0},
        '{CMD_DRAW,   7'd8, 6'd2, 7'h41, 1'b0},
        '{CMD_TOGGLE, 7'd9, 6'd2, 7'd0,  1'b1},
        '{CMD_CLEAR,  7'd0, 6'd0, 7'd0,  1'b0},
        '{CMD_TOGGLE, 7'd8, 6'd2, 7'd0,  1'b1}
    };

    text_console_cursor_control dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic void add_cmd(cmd_t cmd, logic [6:0] col, logic [5:0] row,
                                    logic [6:0] g);
        run_buf[run_len] = '{command: cmd, cell_column: col, cell_row: row,
                             glyph: g, last_of_run: 1'b0};
        run_len++;
    endfunction

    function automatic void advance_row();
        int r;
        r = int'(cur_row) + 1;
        if (r >= int'(screen.bottom_limit)) begin
            add_cmd(CMD_SCROLL, screen.left_column, screen.top_row, 7'd0);
            r = int'(screen.bottom_limit) - 1;    // bottom of 0 pins to row 63
        end
        cur_row = r[5:0];
    endfunction

    function automatic void console_step(in_item_t it);
        logic [6:0] c;
        int         t;
        c = it.char_code[6:0];
        run_len = 0;
        if (it.action == ACT_CLEAR) begin
            // escape phase survives a clear
            add_cmd(CMD_CLEAR, 7'd0, 6'd0, 7'd0);
            cur_col = screen.left_column;
            cur_row = screen.top_row;
        end else begin
            add_cmd(CMD_TOGGLE, cur_col, cur_row, 7'd0);
            if (cur_phase == ESC_SEEN) begin
                cur_phase = (c == CH_LBRACK) ? ESC_CSI : ESC_NORMAL;
            end else if (cur_phase == ESC_CSI) begin
                case (c)
                    CH_UP: begin
                        if (cur_row > screen.top_row) cur_row = cur_row - 6'd1;
                    end
                    CH_RIGHT: begin
                        if (int'(cur_col) + 1 < int'(screen.right_limit))
                            cur_col = cur_col + 7'd1;
                    end
                    CH_ERASE_K: begin
                        if (int'(cur_col) < int'(screen.right_limit))
                            add_cmd(CMD_ERASE_EOL, cur_col, cur_row, 7'd0);
                    end
                    CH_HOME: begin
                        cur_col = screen.left_column;
                        cur_row = screen.top_row;
                    end
                    default: ;
                endcase
                cur_phase = ESC_NORMAL;
            end else if (c >= CH_SPACE && c != CH_DEL) begin
                add_cmd(CMD_DRAW, cur_col, cur_row, c);
                if (int'(cur_col) + 1 >= int'(screen.right_limit)) begin
                    cur_col = screen.left_column;
                    advance_row();
                end else begin
                    cur_col = cur_col + 7'd1;   // wraps mod 128 past a limit of 128
                end
            end else begin
                case (c)
                    CH_BS: begin
                        if (cur_col > screen.left_column) cur_col = cur_col - 7'd1;
                    end
                    CH_HT, CH_VT: begin
                        t = ((int'(cur_col) >> 3) + 1) << 3;
                        if (t < int'(screen.right_limit)) cur_col = t[6:0];
                    end
                    CH_NL: advance_row();
                    CH_CR: cur_col = screen.left_column;
                    CH_ESC: cur_phase = ESC_SEEN;
                    CH_DEL: begin
                        if (cur_col > screen.left_column) begin
                            cur_col = cur_col - 7'd1;
                            add_cmd(CMD_ERASE, cur_col, cur_row, 7'd0);
                        end
                    end
                    default: ;
                endcase
            end
        end
        add_cmd(CMD_TOGGLE, cur_col, cur_row, 7'd0);
        run_buf[run_len - 1].last_of_run = 1'b1;
    endfunction

    function automatic logic [7:0] with_top(logic [6:0] c);
        return {1'($urandom_range(0, 1)), c};
    endfunction

    task automatic send_item(in_item_t it, int n_typed);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        console_step(it);
        if (n_typed == 0) begin
            for (int k = 0; k < run_len; k++) awaited_cmds.push_back(run_buf[k]);
        end else begin
            repeat (n_typed) begin
                awaited_cmds.push_back(dir_typed[typed_pos]);
                typed_pos++;
            end
        end
    endtask

    task automatic put_char(logic [7:0] ch);
        send_item(in_item_t'{ACT_PUT, ch}, 0);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LEFT_COLUMN:  screen.left_column  = val[6:0];
            CFG_RIGHT_LIMIT:  screen.right_limit  = val;
            CFG_TOP_ROW:      screen.top_row      = val[5:0];
            CFG_BOTTOM_LIMIT: screen.bottom_limit = val[6:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed text, control codes and escape sequences; some noise
    task automatic send_random(int count);
        int         sent;
        int         kind;
        int         len;
        logic [6:0] c;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                len = $urandom_range(1, 6);
                repeat (len) put_char(with_top(7'($urandom_range(32, 126))));
                sent += len;
            end else if (kind < 60) begin
                case ($urandom_range(0, 5))
                    0: c = CH_BS;
                    1: c = CH_HT;
                    2: c = CH_VT;
                    3: c = CH_NL;
                    4: c = CH_CR;
                    default: c = CH_DEL;
                endcase
                put_char(with_top(c));
                sent += 1;
            end else if (kind < 82) begin
                put_char(with_top(CH_ESC));
                if ($urandom_range(0, 9) != 0) put_char(with_top(CH_LBRACK));
                else put_char(8'($urandom_range(0, 255)));
                case ($urandom_range(0, 4))
                    0: c = CH_UP;
                    1: c = CH_RIGHT;
                    2: c = CH_ERASE_K;
                    3: c = CH_HOME;
                    default: c = 7'($urandom_range(0, 127));
                endcase
                put_char(with_top(c));
                sent += 3;
            end else if (kind < 90) begin
                send_item(in_item_t'{ACT_CLEAR, 8'($urandom_range(0, 255))}, 0);
                sent += 1;
            end else begin
                put_char(8'($urandom_range(0, 255)));
                sent += 1;
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_cmds.size() == 0) begin
                $display("%0t: unexpected transfer cmd=%0d col=%0d row=%0d glyph=%h last=%b",
                         $time, m_data.command, m_data.cell_column, m_data.cell_row,
                         m_data.glyph, m_data.last_of_run);
                errors++;
            end else begin
                want_cmd = awaited_cmds.pop_front();
                if (m_data.command !== want_cmd.command
                        || m_data.cell_column !== want_cmd.cell_column
                        || m_data.cell_row !== want_cmd.cell_row
                        || m_data.glyph !== want_cmd.glyph
                        || m_data.last_of_run !== want_cmd.last_of_run) begin
                    $display("%0t: mismatch expected cmd=%0d col=%0d row=%0d glyph=%h last=%b",
                             $time, want_cmd.command, want_cmd.cell_column,
                             want_cmd.cell_row, want_cmd.glyph, want_cmd.last_of_run);
                    $display("%0t:          actual cmd=%0d col=%0d row=%0d glyph=%h last=%b",
                             $time, m_data.command, m_data.cell_column, m_data.cell_row,
                             m_data.glyph, m_data.last_of_run);
                    errors++;
                end
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LEFT_COLUMN;
        cfg_data  = '0;
        screen    = '{LEFT_COLUMN_RST, RIGHT_LIMIT_RST, TOP_ROW_RST, BOTTOM_LIMIT_RST};
        cur_col   = LEFT_COLUMN_RST;
        cur_row   = TOP_ROW_RST;
        cur_phase = ESC_NORMAL;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++) send_item(dir_rows[i].item, int'(dir_rows[i].n_typed));

        for (int p = 0; p < N_PHASES; p++) begin
            // hold off until the previous phase has fully drained
            wait_drained();
            if (p == N_PHASES - 1) begin
                screen_plan[p][0] = $urandom_range(0, 127);
                screen_plan[p][1] = $urandom_range(1, 128);
                screen_plan[p][2] = $urandom_range(0, 63);
                screen_plan[p][3] = $urandom_range(1, 64);
            end
            write_reg(CFG_LEFT_COLUMN,  8'(screen_plan[p][0]));
            write_reg(CFG_RIGHT_LIMIT,  8'(screen_plan[p][1]));
            write_reg(CFG_TOP_ROW,      8'(screen_plan[p][2]));
            write_reg(CFG_BOTTOM_LIMIT, 8'(screen_plan[p][3]));
            sender_idle_pct = screen_plan[p][4];
            recv_stall_pct  = screen_plan[p][5];
            send_random(PHASE_ITEMS);
        end

        wait_drained();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
